// ===== sv/tab_pkg.sv =====
// Package for the triangle adjacency builder: table geometry, function codes,
// hash function and the front-to-back command type. No dependencies.
package tab_pkg;
  localparam int TableEntries = 4096;
  localparam int SlotW = $clog2(TableEntries);
  localparam int MaxProbes = 16;
  localparam int ProbeW = $clog2(MaxProbes + 1);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncClear  = 2'd2;
  localparam logic [1:0] FuncNop    = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] va;
    logic [15:0] vb;
    logic [15:0] vc;
  } cmd_t;

  // Hash is split in two stages by the caller: multiply, then fold.
  // Only the low 32 bits of the product are kept.
  function automatic logic [31:0] hash_mul(input logic [31:0] key);
    logic [31:0] p;
    p = key * 32'd2654435761;
    return p;
  endfunction

  function automatic logic [SlotW-1:0] hash_fold(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> 16);
    return f[SlotW-1:0];
  endfunction
endpackage

// ===== sv/tab_front.sv =====
// Front part: accepts words, drops no-op codes, and queues commands.
// Depends on tab_pkg.
module tab_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_func,
  input  logic [15:0]    in_vertex_a,
  input  logic [15:0]    in_vertex_b,
  input  logic [15:0]    in_vertex_c,
  output logic           q_valid,
  input  logic           q_pop,
  output tab_pkg::cmd_t  q_cmd
);
  tab_pkg::cmd_t mem_r [tab_pkg::QDepth];
  logic [tab_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [tab_pkg::QPtrW:0]   cnt_r;
  logic push, keep;

  assign in_ready = (cnt_r != (tab_pkg::QPtrW+1)'(tab_pkg::QDepth));
  assign keep = (in_func != tab_pkg::FuncNop);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{in_func, in_vertex_a, in_vertex_b, in_vertex_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (tab_pkg::QPtrW+1)'(push) - (tab_pkg::QPtrW+1)'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (tab_pkg::QPtrW+1)'(tab_pkg::QDepth)) else $error("queue count overrun");
  a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (tab_pkg::QPtrW+1)'(tab_pkg::QDepth)) |-> !in_ready)
    else $error("ready while full");
endmodule

// ===== sv/tab_back.sv =====
// Back part: hashed half-edge table with linear probing, clearing sweep,
// and result register. Depends on tab_pkg.
module tab_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    vcount,
  input  logic           q_valid,
  output logic           q_pop,
  input  tab_pkg::cmd_t  q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_index,
  output logic           out_is_adjacent_slot,
  output logic           out_neighbour_missing,
  output logic           out_first_sentinel,
  output logic           out_table_overflowed,
  output logic           out_last
);
  localparam int SW = tab_pkg::SlotW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FOLD, S_READ, S_PROBE, S_EMIT0, S_EMIT1
  } state_t;

  state_t state_r;
  logic [31:0] key_mem [tab_pkg::TableEntries];
  logic [15:0] opp_mem [tab_pkg::TableEntries];
  logic        vld_mem [tab_pkg::TableEntries];

  tab_pkg::cmd_t cmd_r;
  logic [1:0]  edge_r;
  logic [31:0] key_r, h_r;
  logic [SW-1:0] slot_r;
  logic [tab_pkg::ProbeW-1:0] probe_r;
  logic [31:0] rkey_r;
  logic [15:0] ropp_r;
  logic        rvld_r;
  logic        sent_r, ovf_r;
  logic [15:0] adj_r;
  logic        miss_r, first_r;
  logic        wr_en;
  logic [SW-1:0] wr_slot;
  logic [31:0] wr_key;
  logic [15:0] wr_opp;
  logic        wr_vld;
  logic [15:0] v0, v1, v2;
  logic        is_ins, hit;

  // edge e: (v0,v1) with opposite v2
  always_comb begin
    unique case (edge_r)
      2'd0: begin v0 = cmd_r.va; v1 = cmd_r.vb; v2 = cmd_r.vc; end
      2'd1: begin v0 = cmd_r.vb; v1 = cmd_r.vc; v2 = cmd_r.va; end
      default: begin v0 = cmd_r.vc; v1 = cmd_r.va; v2 = cmd_r.vb; end
    endcase
  end

  assign is_ins = (cmd_r.func == tab_pkg::FuncInsert);
  assign hit = rvld_r && (rkey_r == key_r);
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    wr_en = 1'b0; wr_slot = slot_r; wr_key = key_r; wr_opp = v2; wr_vld = 1'b1;
    if (state_r == S_CLEAR) begin
      wr_en = 1'b1; wr_vld = 1'b0;
    end else if (state_r == S_PROBE && is_ins && (!rvld_r || hit)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_slot] <= wr_key;
      opp_mem[wr_slot] <= wr_opp;
      vld_mem[wr_slot] <= wr_vld;
    end
    rkey_r <= key_mem[slot_r];
    ropp_r <= opp_mem[slot_r];
    rvld_r <= vld_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      slot_r <= '0;
      sent_r <= 1'b0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      edge_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          slot_r <= slot_r + 1'b1;
          if (slot_r == SW'(tab_pkg::TableEntries - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            edge_r <= '0;
            if (q_cmd.func == tab_pkg::FuncClear) begin
              sent_r <= 1'b0;
              ovf_r <= 1'b0;
              slot_r <= '0;
              state_r <= S_CLEAR;
            end else state_r <= S_HASH;
          end
        end
        S_HASH: begin
          // query looks up the reversed half-edge
          key_r <= is_ins ? {v0, v1} : {v1, v0};
          h_r <= tab_pkg::hash_mul(is_ins ? {v0, v1} : {v1, v0});
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          slot_r <= tab_pkg::hash_fold(h_r);
          probe_r <= '0;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_PROBE;
        S_PROBE: begin
          if (is_ins) begin
            if (!rvld_r || hit) state_r <= (edge_r == 2'd2) ? S_IDLE : S_HASH;
            else if (probe_r == tab_pkg::ProbeW'(tab_pkg::MaxProbes - 1)) begin
              ovf_r <= 1'b1;
              state_r <= (edge_r == 2'd2) ? S_IDLE : S_HASH;
            end else begin
              slot_r <= slot_r + 1'b1;
              probe_r <= probe_r + 1'b1;
              state_r <= S_READ;
            end
            if (!rvld_r || hit || probe_r == tab_pkg::ProbeW'(tab_pkg::MaxProbes - 1))
              edge_r <= edge_r + 1'b1;
          end else begin
            if (hit || !rvld_r || probe_r == tab_pkg::ProbeW'(tab_pkg::MaxProbes - 1)) begin
              adj_r <= hit ? ropp_r : vcount;
              miss_r <= !hit;
              first_r <= !hit && !sent_r;
              if (!hit) sent_r <= 1'b1;
              out_valid <= 1'b1;
              out_index <= v0;
              out_is_adjacent_slot <= 1'b0;
              out_neighbour_missing <= 1'b0;
              out_first_sentinel <= 1'b0;
              out_table_overflowed <= ovf_r;
              out_last <= 1'b0;
              state_r <= S_EMIT0;
            end else begin
              slot_r <= slot_r + 1'b1;
              probe_r <= probe_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_EMIT0: begin
          if (out_ready) begin
            out_index <= adj_r;
            out_is_adjacent_slot <= 1'b1;
            out_neighbour_missing <= miss_r;
            out_first_sentinel <= first_r;
            out_last <= (edge_r == 2'd2);
            state_r <= S_EMIT1;
          end
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            edge_r <= edge_r + 1'b1;
            state_r <= (edge_r == 2'd2) ? S_IDLE : S_HASH;
          end
        end
      endcase
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT0 || state_r == S_EMIT1) |-> out_valid) else $error("emit without valid");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_index)) else $error("result changed while stalled");
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    edge_r != 2'd3 || state_r == S_IDLE || state_r == S_CLEAR) else $error("edge index overrun");
endmodule

// ===== sv/triangle_adjacency_builder.sv =====
// Top level of the triangle adjacency builder: configuration register,
// front queue and back table engine. Depends on tab_pkg, tab_front, tab_back.
//
// Usage: drive triangles on the in_ channel (valid/ready) with a function code:
// insert stores three half-edges, query returns six words on the out_ channel
// (corner, adjacent, per edge; last marks the sixth), clear empties the table.
// Program cfg_wdata (sentinel index) while idle; writes take effect at once.
// After reset the back part sweeps all 4096 table slots, one per cycle, before
// it takes the first command; a clear repeats that sweep. The front queue
// holds four commands, so input is accepted during the sweep until full. Each
// half-edge passes S_HASH and S_FOLD, then S_READ and S_PROBE per probed slot
// through the single table memory port; a query also emits two output words
// per edge, and the probe run is bounded at 16 slots. With the back part idle,
// an accepted query passes the front queue, then S_IDLE, S_HASH, S_FOLD, S_READ
// and S_PROBE before its first word is valid. A stalled receiver holds the out_
// word and the back part; the front keeps queueing until its queue is full.
module triangle_adjacency_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_vertex_a,
  input  logic [15:0] in_vertex_b,
  input  logic [15:0] in_vertex_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_index,
  output logic        out_is_adjacent_slot,
  output logic        out_neighbour_missing,
  output logic        out_first_sentinel,
  output logic        out_table_overflowed,
  output logic        out_last
);
  logic [15:0] vcount_r;
  logic q_valid, q_pop;
  tab_pkg::cmd_t q_cmd;

  // hold the sentinel index
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= '0;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  tab_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_vertex_a, .in_vertex_b,
    .in_vertex_c, .q_valid, .q_pop, .q_cmd
  );

  tab_back u_back (
    .clk, .rst_n, .vcount(vcount_r), .q_valid, .q_pop, .q_cmd, .out_valid,
    .out_ready, .out_index, .out_is_adjacent_slot, .out_neighbour_missing,
    .out_first_sentinel, .out_table_overflowed, .out_last
  );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for triangle_adjacency_builder: directed and random
// insert/query/clear traffic checked word by word against an in-bench model.
// Depends on tab_pkg (function codes, table geometry) and the triangle_adjacency_builder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = tab_pkg::TableEntries;
  localparam int Probes = tab_pkg::MaxProbes;
  // Covers the command in the back part plus a full queue, all clear sweeps.
  localparam int IdleWait = 21000;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] a, b, c;
    bit          drain;   // marker: hold the sender until every word is back
  } tri_item_t;

  typedef struct {
    logic [15:0] index;
    logic        adj, miss, first, ovf, last;
  } adj_word_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_func = '0;
  logic [15:0] in_vertex_a = '0, in_vertex_b = '0, in_vertex_c = '0;
  logic out_valid, out_ready = 1'b0;
  logic [15:0] out_index;
  logic out_is_adjacent_slot, out_neighbour_missing, out_first_sentinel;
  logic out_table_overflowed, out_last;

  triangle_adjacency_builder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b), .in_vertex_c(in_vertex_c),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_is_adjacent_slot(out_is_adjacent_slot),
    .out_neighbour_missing(out_neighbour_missing),
    .out_first_sentinel(out_first_sentinel),
    .out_table_overflowed(out_table_overflowed), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Half-edge table mirror and flags
  logic [31:0] he_key [Slots];
  logic [15:0] he_opp [Slots];
  bit          he_used [Slots];
  bit          sentinel_taken, overflow_seen;
  logic [15:0] sentinel_index;

  tri_item_t   pend_tris[$];
  adj_word_t   adj_expect[$];
  tri_item_t   inserted[$];
  int          errors = 0;
  bit          in_taken = 1'b0;
  int          stall_req = 0, stall_done = 0, hold_cnt = 0;
  // No random idling on either side while set
  bit          quiet = 1'b0;

  function automatic int home_of(logic [15:0] v0, logic [15:0] v1);
    logic [63:0] p;
    logic [31:0] h;
    p = {32'd0, v0, v1} * 64'd2654435761;
    h = p[31:0];
    h = h ^ (h >> 16);
    return int'(h[tab_pkg::SlotW-1:0]);
  endfunction

  task automatic store_half_edge(logic [15:0] v0, logic [15:0] v1, logic [15:0] o);
    int s;
    s = home_of(v0, v1);
    for (int p = 0; p < Probes; p++) begin
      if (!he_used[s]) begin
        he_used[s] = 1'b1;
        he_key[s] = {v0, v1};
        he_opp[s] = o;
        return;
      end
      if (he_key[s] == {v0, v1}) begin
        he_opp[s] = o;
        return;
      end
      s = (s + 1) % Slots;
    end
    overflow_seen = 1'b1;
  endtask

  function automatic bit find_half_edge(logic [15:0] v0, logic [15:0] v1,
                                        output logic [15:0] o);
    int s;
    s = home_of(v0, v1);
    o = '0;
    for (int p = 0; p < Probes; p++) begin
      if (!he_used[s]) return 1'b0;
      if (he_key[s] == {v0, v1}) begin
        o = he_opp[s];
        return 1'b1;
      end
      s = (s + 1) % Slots;
    end
    return 1'b0;
  endfunction

  // Advance the model by one accepted triangle, queue the words it must produce
  task automatic apply_triangle(tri_item_t t);
    logic [15:0] v [3];
    logic [15:0] o;
    bit hit;
    adj_word_t w;
    v[0] = t.a; v[1] = t.b; v[2] = t.c;
    case (t.func)
      tab_pkg::FuncInsert: begin
        for (int e = 0; e < 3; e++) store_half_edge(v[e], v[(e+1)%3], v[(e+2)%3]);
      end
      tab_pkg::FuncClear: begin
        for (int i = 0; i < Slots; i++) he_used[i] = 1'b0;
        sentinel_taken = 1'b0;
        overflow_seen = 1'b0;
      end
      tab_pkg::FuncQuery: begin
        for (int e = 0; e < 3; e++) begin
          hit = find_half_edge(v[(e+1)%3], v[e], o);
          w = '{index: v[e], adj: 1'b0, miss: 1'b0, first: 1'b0,
                ovf: overflow_seen, last: 1'b0};
          adj_expect = {adj_expect, w};
          w.adj = 1'b1;
          w.last = (e == 2);
          if (!hit) begin
            w.index = sentinel_index;
            w.miss = 1'b1;
            w.first = !sentinel_taken;
            sentinel_taken = 1'b1;
          end else begin
            w.index = o;
          end
          adj_expect = {adj_expect, w};
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    adj_word_t w;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) sentinel_index = cfg_wdata;
      if (in_valid && in_ready)
        apply_triangle('{func: in_func, a: in_vertex_a, b: in_vertex_b,
                         c: in_vertex_c, drain: 1'b0});
      if (out_valid && out_ready) begin
        if (adj_expect.size() == 0) begin
          report("unexpected word", out_index, '0);
        end else begin
          w = adj_expect.pop_front();
          if (out_index != w.index) report("index", out_index, w.index);
          if (out_is_adjacent_slot != w.adj)
            report("adjacent_slot", 16'(out_is_adjacent_slot), 16'(w.adj));
          if (out_neighbour_missing != w.miss)
            report("missing", 16'(out_neighbour_missing), 16'(w.miss));
          if (out_first_sentinel != w.first)
            report("first_sentinel", 16'(out_first_sentinel), 16'(w.first));
          if (out_table_overflowed != w.ovf)
            report("overflowed", 16'(out_table_overflowed), 16'(w.ovf));
          if (out_last != w.last) report("last", 16'(out_last), 16'(w.last));
        end
      end
    end
  end

  // Sender: hold an offered word until taken, then advance to the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // drop a drain marker only once the output side is empty
      if (pend_tris.size() > 0 && pend_tris[0].drain && adj_expect.size() == 0 && !in_valid)
        void'(pend_tris.pop_front());
      if (pend_tris.size() > 0 && !pend_tris[0].drain &&
          (quiet || $urandom_range(99) >= 12)) begin
        in_valid <= 1'b1;
        in_func <= pend_tris[0].func;
        in_vertex_a <= pend_tris[0].a;
        in_vertex_b <= pend_tris[0].b;
        in_vertex_c <= pend_tris[0].c;
        void'(pend_tris.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_req != stall_done && hold_cnt == 0) begin
      hold_cnt <= 400;
      stall_done <= stall_done + 1;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  task automatic add_tri(logic [1:0] f, logic [15:0] a, logic [15:0] b, logic [15:0] c);
    tri_item_t t;
    t = '{func: f, a: a, b: b, c: c, drain: 1'b0};
    pend_tris = {pend_tris, t};
    if (f == tab_pkg::FuncInsert) inserted = {inserted, t};
  endtask

  task automatic add_drain();
    tri_item_t t;
    t = '{func: tab_pkg::FuncNop, a: '0, b: '0, c: '0, drain: 1'b1};
    pend_tris = {pend_tris, t};
  endtask

  function automatic logic [15:0] pick_vertex();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(63));
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (pend_tris.size() > 0 || in_valid || adj_expect.size() > 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    tri_item_t t;
    int r;
    stall_req++;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35 || inserted.size() == 0) begin
        add_tri(tab_pkg::FuncInsert, pick_vertex(), pick_vertex(), pick_vertex());
      end else if (r < 72) begin
        // neighbour of a stored triangle: shares a reversed edge
        t = inserted[$urandom_range(inserted.size() - 1)];
        add_tri(tab_pkg::FuncQuery, t.b, t.a, pick_vertex());
      end else if (r < 82) begin
        t = inserted[$urandom_range(inserted.size() - 1)];
        add_tri(tab_pkg::FuncQuery, t.c, t.b, t.a);
      end else if (r < 92) begin
        add_tri(tab_pkg::FuncQuery, pick_vertex(), pick_vertex(), pick_vertex());
      end else if (r < 97) begin
        add_tri(tab_pkg::FuncNop, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 98) begin
        add_tri(tab_pkg::FuncClear, 16'($urandom), 16'($urandom), 16'($urandom));
        inserted.delete();
      end else begin
        add_drain();
      end
    end
  endtask

  initial begin
    logic [15:0] crowd_a [$];
    logic [15:0] crowd_b [$];
    int home;
    sentinel_index = '0;
    sentinel_taken = 1'b0;
    overflow_seen = 1'b0;
    for (int i = 0; i < Slots; i++) he_used[i] = 1'b0;

    // Find 17 half-edges that share one home slot to force overflow
    home = home_of(16'd7, 16'd0);
    for (int k = 0; k < 32'h0040_0000 && crowd_b.size() < Probes + 1; k++)
      if (home_of(16'(k >> 16), 16'(k)) == home) begin
        crowd_a = {crowd_a, 16'(k >> 16)};
        crowd_b = {crowd_b, 16'(k)};
      end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: misses on an empty table, extremes, re-insert, degenerate
    add_tri(tab_pkg::FuncQuery, 16'd0, 16'hFFFF, 16'd1);
    add_tri(tab_pkg::FuncInsert, 16'd0, 16'hFFFF, 16'd1);
    add_tri(tab_pkg::FuncQuery, 16'hFFFF, 16'd0, 16'd2);
    add_tri(tab_pkg::FuncInsert, 16'd0, 16'hFFFF, 16'hFFFF);
    add_tri(tab_pkg::FuncQuery, 16'hFFFF, 16'd0, 16'd2);
    add_tri(tab_pkg::FuncNop, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_tri(tab_pkg::FuncInsert, 16'd5, 16'd5, 16'd5);
    add_tri(tab_pkg::FuncQuery, 16'd5, 16'd5, 16'd5);
    add_drain();
    foreach (crowd_b[i]) add_tri(tab_pkg::FuncInsert, crowd_a[i], crowd_b[i], 16'(i));
    add_tri(tab_pkg::FuncQuery, crowd_b[0], crowd_a[0], 16'd9);
    add_tri(tab_pkg::FuncQuery, crowd_b[Probes], crowd_a[Probes], 16'd9);
    add_tri(tab_pkg::FuncClear, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    inserted.delete();
    add_tri(tab_pkg::FuncQuery, 16'hFFFF, 16'd0, 16'd2);
    wait_idle();

    write_vertex_count(16'hFFFF);
    random_phase(82);
    wait_idle();
    write_vertex_count(16'($urandom));
    quiet = 1'b1;
    random_phase(82);
    wait_idle();
    quiet = 1'b0;
    write_vertex_count(16'd1);
    random_phase(82);
    wait_idle();
    write_vertex_count(16'd0);
    random_phase(60);
    wait_idle();

    if (errors == 0 && adj_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
